// ----- rtl/clustering_fmeasure_scorer_core_assert.svh -----
// assertion macros shared by the scorer modules
// each macro samples on clk and is disabled while rst_n is low
`ifndef CLUSTERING_FMEASURE_SCORER_CORE_ASSERT_SVH
`define CLUSTERING_FMEASURE_SCORER_CORE_ASSERT_SVH

// condition holds at every clock edge
`define CFS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cfs_pkg
// shared widths, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package cfs_pkg;

  localparam int CLUSTER_W = 6;
  localparam int PAIR_AW   = 2 * CLUSTER_W;
  localparam int CNT_W     = 16;
  localparam int Q_W       = 17;
  localparam int PROD_W    = Q_W + CNT_W;
  localparam int DIV_STEPS = Q_W;
  localparam int DCNT_W    = 5;
  localparam int PAIR_DEPTH = 1 << PAIR_AW;
  localparam int SIZE_DEPTH = 1 << CLUSTER_W;

  localparam logic [Q_W-1:0]   Q16_ONE   = 17'h10000;
  localparam logic [CNT_W-1:0] COUNT_CAP = 16'hFFFF;

  // transaction modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_SCORE = 1'b1;

  // commands from the controller
  typedef struct packed {
    logic walk_addr;
    logic load;
    logic drop;
    logic mem_we;
    logic mem_zero;
    logic k_inc;
    logic check;
    logic best_update;
    logic mul_en;
    logic term_start;
    logic sum_add;
    logic out_load;
    logic run_clear;
  } cfs_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic k_last;
    logic o_last;
    logic n_nz;
    logic rs_nz;
    logic div_busy;
    logic count_full;
    logic out_pending;
  } cfs_status_t;

endpackage

`default_nettype wire

// ----- rtl/cfs_ram.sv -----
// ----------------------------------------------------------------------------
// cfs_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- rtl/cfs_datapath.sv -----
// ----------------------------------------------------------------------------
// cfs_datapath
// count tables, shared iterative divider, weighting multiplier and score sum
// ----------------------------------------------------------------------------
`default_nettype none

`include "clustering_fmeasure_scorer_core_assert.svh"

module cfs_datapath
  import cfs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfs_cmd_t             cmd,
  output cfs_status_t               status,
  input  wire logic [CLUSTER_W-1:0] in_ref_cluster,
  input  wire logic [CLUSTER_W-1:0] in_other_cluster,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [Q_W-1:0]            out_fscore,
  output logic [CNT_W-1:0]          out_item_total,
  output logic                      out_overflow
);

  logic [PAIR_AW-1:0]   k_r;
  logic [CLUSTER_W-1:0] rc_r, oc_r;
  logic [CNT_W-1:0]     count_r;
  logic                 flag_r;
  logic [CNT_W-1:0]     rs_r;
  logic [Q_W-1:0]       best_r;
  logic [PROD_W-1:0]    prod_r;
  logic [Q_W-1:0]       sum_r;
  logic [Q_W-1:0]       rem_r, dvd_r, den_r;
  logic [DCNT_W-1:0]    cnt_r;
  logic                 out_valid_r;
  logic [Q_W-1:0]       fscore_r;
  logic [CNT_W-1:0]     total_r;
  logic                 ovf_r;

  logic [PAIR_AW-1:0]   pair_addr;
  logic [CLUSTER_W-1:0] ref_addr, other_addr;
  logic [CNT_W-1:0]     pair_rd, ref_rd, other_rd;
  logic [CNT_W-1:0]     pair_wd, ref_wd, other_wd;
  logic [Q_W:0]         trial;
  logic                 ge;

  // table addressing: walk index or latched cluster pair
  assign pair_addr  = cmd.walk_addr ? k_r : {rc_r, oc_r};
  assign ref_addr   = cmd.walk_addr ? k_r[PAIR_AW-1:CLUSTER_W] : rc_r;
  assign other_addr = cmd.walk_addr ? k_r[CLUSTER_W-1:0] : oc_r;
  assign pair_wd    = cmd.mem_zero ? '0 : pair_rd + 1'b1;
  assign ref_wd     = cmd.mem_zero ? '0 : ref_rd + 1'b1;
  assign other_wd   = cmd.mem_zero ? '0 : other_rd + 1'b1;

  cfs_ram #(.WIDTH(CNT_W), .DEPTH(PAIR_DEPTH)) u_pair (
    .clk(clk), .we(cmd.mem_we), .addr(pair_addr), .wdata(pair_wd), .rdata(pair_rd)
  );

  cfs_ram #(.WIDTH(CNT_W), .DEPTH(SIZE_DEPTH)) u_ref (
    .clk(clk), .we(cmd.mem_we), .addr(ref_addr), .wdata(ref_wd), .rdata(ref_rd)
  );

  cfs_ram #(.WIDTH(CNT_W), .DEPTH(SIZE_DEPTH)) u_other (
    .clk(clk), .we(cmd.mem_we), .addr(other_addr), .wdata(other_wd), .rdata(other_rd)
  );

  // one restoring division step
  assign trial = {rem_r, dvd_r[Q_W-1]} - {1'b0, den_r};
  assign ge    = ({rem_r, dvd_r[Q_W-1]} >= {1'b0, den_r});

  // walk index, counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      count_r <= '0;
      flag_r  <= 1'b0;
      sum_r   <= '0;
    end else begin
      if (cmd.k_inc) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.run_clear) begin
        count_r <= '0;
        flag_r  <= 1'b0;
        sum_r   <= '0;
      end else begin
        if (cmd.load) begin
          count_r <= count_r + 1'b1;
        end
        if (cmd.drop) begin
          flag_r <= 1'b1;
        end
        if (cmd.sum_add) begin
          sum_r <= sum_r + dvd_r;
        end
      end
    end
  end

  // latched pair, row size, best f value and weighting product
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rc_r <= in_ref_cluster;
      oc_r <= in_other_cluster;
    end
    if (cmd.check) begin
      rs_r <= ref_rd;
    end
    if (cmd.check && (k_r[CLUSTER_W-1:0] == '0)) begin
      best_r <= '0;
    end else if (cmd.best_update && (dvd_r > best_r)) begin
      best_r <= dvd_r;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(best_r) * PROD_W'(rs_r);
    end
  end

  // shared divider: f value per pair, weighted term per row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.check && (pair_rd != '0)) begin
      cnt_r <= DCNT_W'(DIV_STEPS);
    end else if (cmd.term_start) begin
      cnt_r <= DCNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check && (pair_rd != '0)) begin
      rem_r <= {1'b0, pair_rd};
      dvd_r <= '0;
      den_r <= {1'b0, ref_rd} + {1'b0, other_rd};
    end else if (cmd.term_start) begin
      rem_r <= {1'b0, prod_r[PROD_W-1:Q_W]};
      dvd_r <= prod_r[Q_W-1:0];
      den_r <= {1'b0, count_r};
    end else if (cnt_r != '0) begin
      rem_r <= ge ? trial[Q_W-1:0] : {rem_r[Q_W-2:0], dvd_r[Q_W-1]};
      dvd_r <= {dvd_r[Q_W-2:0], ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fscore_r <= sum_r;
      total_r  <= count_r;
      ovf_r    <= flag_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fscore     = fscore_r;
  assign out_item_total = total_r;
  assign out_overflow   = ovf_r;

  // status
  assign status.k_last      = &k_r;
  assign status.o_last      = &k_r[CLUSTER_W-1:0];
  assign status.n_nz        = (pair_rd != '0);
  assign status.rs_nz       = (rs_r != '0);
  assign status.div_busy    = (cnt_r != '0);
  assign status.count_full  = (count_r == COUNT_CAP);
  assign status.out_pending = out_valid_r;

  // checks
  `CFS_ASSERT(a_sum_range, sum_r <= Q16_ONE, "score sum above one")
  `CFS_ASSERT(a_div_cnt, cnt_r <= DCNT_W'(DIV_STEPS), "divider step count out of range")
  `CFS_ASSERT_NEXT(a_out_load, cmd.out_load, out_valid_r, "result not presented after load")

endmodule

`default_nettype wire

// ----- rtl/cfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfs_ctrl
// controller: table clear sweep, load read-modify-write and score walk
// ----------------------------------------------------------------------------
`default_nettype none

`include "clustering_fmeasure_scorer_core_assert.svh"

module cfs_ctrl
  import cfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_mode,
  output logic             in_stall,
  input  wire cfs_status_t status,
  output cfs_cmd_t         cmd
);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LD_RD = 4'd2;
  localparam logic [3:0] ST_LD_WR = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_CHK   = 4'd5;
  localparam logic [3:0] ST_DIVF  = 4'd6;
  localparam logic [3:0] ST_NEXT  = 4'd7;
  localparam logic [3:0] ST_MUL   = 4'd8;
  localparam logic [3:0] ST_TST   = 4'd9;
  localparam logic [3:0] ST_DIVT  = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       accept;
  logic       load_go;

  // input handshake: idle only, score waits for a pending result
  assign in_stall = (state_r != ST_IDLE) || (status.out_pending && (in_mode != MODE_LOAD));
  assign accept   = in_valid && !in_stall;
  assign load_go  = accept && (in_mode == MODE_LOAD) && !status.count_full;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.walk_addr = 1'b1;
        cmd.mem_we    = 1'b1;
        cmd.mem_zero  = 1'b1;
        cmd.k_inc     = 1'b1;
        if (status.k_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_LOAD) begin
            if (status.count_full) begin
              cmd.drop = 1'b1;
            end else begin
              cmd.load  = 1'b1;
              state_nxt = ST_LD_RD;
            end
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_LD_RD: begin
        state_nxt = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd.mem_we = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RD: begin
        cmd.walk_addr = 1'b1;
        state_nxt     = ST_CHK;
      end
      ST_CHK: begin
        cmd.walk_addr = 1'b1;
        cmd.check     = 1'b1;
        state_nxt     = status.n_nz ? ST_DIVF : ST_NEXT;
      end
      ST_DIVF: begin
        if (!status.div_busy) begin
          cmd.best_update = 1'b1;
          state_nxt       = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (status.o_last) begin
          state_nxt = ST_MUL;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_TST;
      end
      ST_TST: begin
        if (status.rs_nz) begin
          cmd.term_start = 1'b1;
          state_nxt      = ST_DIVT;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = status.k_last ? ST_OUT : ST_RD;
        end
      end
      ST_DIVT: begin
        if (!status.div_busy) begin
          cmd.sum_add = 1'b1;
          cmd.k_inc   = 1'b1;
          state_nxt   = status.k_last ? ST_OUT : ST_RD;
        end
      end
      ST_OUT: begin
        cmd.out_load  = 1'b1;
        cmd.run_clear = 1'b1;
        state_nxt     = ST_CLR;
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  `CFS_ASSERT(a_stall_busy, (state_r == ST_IDLE) || in_stall, "transaction taken while busy")
  `CFS_ASSERT_NEXT(a_load_seq, load_go, state_r == ST_LD_RD, "load not followed by read")
  `CFS_ASSERT(a_rd_idle_div, (state_r != ST_RD) || !status.div_busy, "divider busy at walk read")

endmodule

`default_nettype wire

// ----- rtl/clustering_fmeasure_scorer_core.sv -----
// ----------------------------------------------------------------------------
// clustering_fmeasure_scorer_core
// weighted f-measure of a clustering against a reference clustering
// ----------------------------------------------------------------------------
// usage:
//   in channel: a transaction with in_mode 0 counts one element's pair
//   (in_ref_cluster, in_other_cluster); in_mode 1 requests the score.
//   out channel: one transaction per score request carrying out_fscore
//   (unsigned q16), out_item_total and out_overflow.
// sequence:
//   a load steps through accept, table read and increment write-back.
//   a score walks all 4096 pair entries (read, check, next) and, per
//   reference row, multiply and term; each nonzero pair and each nonempty
//   row runs the 17-step shared divider; the result is loaded after the
//   walk and a clearing sweep of all 4096 table entries follows.
// reset: the same clearing sweep runs; in_stall stays high through it.
// stall: the result is held in the output register while out_stall is
//   high; loads are still taken, a new score request waits.
// ----------------------------------------------------------------------------
`default_nettype none

module clustering_fmeasure_scorer_core
  import cfs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_mode,
  input  wire logic [CLUSTER_W-1:0] in_ref_cluster,
  input  wire logic [CLUSTER_W-1:0] in_other_cluster,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [Q_W-1:0]            out_fscore,
  output logic [CNT_W-1:0]          out_item_total,
  output logic                      out_overflow
);

  cfs_cmd_t    cmd;
  cfs_status_t status;

  // controller
  cfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  cfs_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_ref_cluster   (in_ref_cluster),
    .in_other_cluster (in_other_cluster),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fscore       (out_fscore),
    .out_item_total   (out_item_total),
    .out_overflow     (out_overflow)
  );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for clustering_fmeasure_scorer_core. Load and score
// transactions are queued by phase. A scoring model of the contingency table
// predicts each score result, and the monitor checks results field by field
// under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import cfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_LIMIT = 65535;
  localparam int WDOG_LIMIT = 200000;
  localparam int HOLD_LEN   = 40000;

  typedef struct packed {
    logic                 mode;
    logic [CLUSTER_W-1:0] ref_cl;
    logic [CLUSTER_W-1:0] oth_cl;
  } elem_t;

  typedef struct packed {
    logic [Q_W-1:0]   fscore;
    logic [CNT_W-1:0] total;
    logic             ovf;
  } score_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [CLUSTER_W-1:0] in_ref_cluster = '0;
  logic [CLUSTER_W-1:0] in_other_cluster = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [Q_W-1:0] out_fscore;
  logic [CNT_W-1:0] out_item_total;
  logic out_overflow;

  elem_t  pending_q[$];
  score_t score_q[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_req = 1'b0;
  int     hold_cnt = 0;
  int     quiet_cycles = 0;

  // scoring model state
  int unsigned pair_cnt[PAIR_DEPTH];
  int unsigned ref_sz[SIZE_DEPTH];
  int unsigned oth_sz[SIZE_DEPTH];
  int unsigned elem_cnt;
  bit          dropped;

  clustering_fmeasure_scorer_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_ref_cluster(in_ref_cluster), .in_other_cluster(in_other_cluster),
    .out_valid(out_valid), .out_stall(out_stall), .out_fscore(out_fscore),
    .out_item_total(out_item_total), .out_overflow(out_overflow)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_table();
    foreach (pair_cnt[i]) pair_cnt[i] = 0;
    foreach (ref_sz[i]) begin
      ref_sz[i] = 0;
      oth_sz[i] = 0;
    end
    elem_cnt = 0;
    dropped = 1'b0;
  endfunction

  // weighted best-match f-measure over the contingency table
  function automatic longint unsigned weighted_fscore();
    longint unsigned sum, best, fq, n, rs;
    sum = 0;
    if (elem_cnt == 0) return 0;
    for (int r = 0; r < SIZE_DEPTH; r++) begin
      rs = ref_sz[r];
      best = 0;
      if (rs == 0) continue;
      for (int o = 0; o < SIZE_DEPTH; o++) begin
        n = pair_cnt[r * SIZE_DEPTH + o];
        if (n == 0) continue;
        fq = (2 * n * 65536) / (rs + oth_sz[o]);
        if (fq > best) best = fq;
      end
      sum += (best * rs) / elem_cnt;
    end
    if (sum > 65536) sum = 65536;
    return sum;
  endfunction

  // update the table for one accepted transaction
  function automatic void apply_elem(elem_t e);
    score_t s;
    if (e.mode == MODE_LOAD) begin
      if (elem_cnt >= ITEM_LIMIT) begin
        dropped = 1'b1;
      end else begin
        pair_cnt[{e.ref_cl, e.oth_cl}]++;
        ref_sz[e.ref_cl]++;
        oth_sz[e.oth_cl]++;
        elem_cnt++;
      end
    end else begin
      s.fscore = Q_W'(weighted_fscore());
      s.total = elem_cnt[CNT_W-1:0];
      s.ovf = dropped;
      score_q.insert(score_q.size(), s);
      clear_table();
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      apply_elem('{in_mode, in_ref_cluster, in_other_cluster});
    end
    if (!in_valid || !in_stall) begin
      if (rst_n && pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        elem_t e;
        e = pending_q.pop_front();
        in_valid <= 1'b1;
        in_mode <= e.mode;
        in_ref_cluster <= e.ref_cl;
        in_other_cluster <= e.oth_cl;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (score_q.size() == 0) begin
        $error("unexpected result fscore=%0d item_total=%0d", out_fscore, out_item_total);
        errors++;
      end else begin
        score_t s;
        s = score_q.pop_front();
        if (out_fscore !== s.fscore) begin
          $error("fscore expected %0d actual %0d", s.fscore, out_fscore);
          errors++;
        end
        if (out_item_total !== s.total) begin
          $error("item_total expected %0d actual %0d", s.total, out_item_total);
          errors++;
        end
        if (out_overflow !== s.ovf) begin
          $error("overflow expected %0d actual %0d", s.ovf, out_overflow);
          errors++;
        end
      end
    end
    if (hold_req && hold_cnt == 0) hold_cnt = HOLD_LEN;
    if (hold_cnt > 0) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_req = 1'b0;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push(bit mode, int rc, int oc);
    elem_t e;
    e = '{mode, rc[CLUSTER_W-1:0], oc[CLUSTER_W-1:0]};
    pending_q.insert(pending_q.size(), e);
  endtask

  // one run of loads with a noisy cluster mapping, then a score request
  task automatic push_run(int n_loads);
    int span, shift, noise, rc;
    span = $urandom_range(1, 64);
    shift = $urandom_range(63);
    noise = $urandom_range(0, 60);
    for (int i = 0; i < n_loads; i++) begin
      rc = $urandom_range(span - 1);
      if ($urandom_range(99) < noise) push(MODE_LOAD, $urandom_range(63), $urandom_range(63));
      else push(MODE_LOAD, rc, (rc + shift) % 64);
    end
    push(MODE_SCORE, $urandom_range(63), $urandom_range(63));
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || score_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    clear_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty run, extremes, perfect match
    push(MODE_SCORE, 63, 63);
    push(MODE_LOAD, 0, 0);
    push(MODE_LOAD, 63, 63);
    push(MODE_LOAD, 0, 63);
    push(MODE_LOAD, 63, 0);
    push(MODE_LOAD, 21, 42);
    push(MODE_LOAD, 42, 21);
    push(MODE_SCORE, 0, 0);
    push(MODE_LOAD, 5, 9);
    push(MODE_SCORE, 42, 21);
    drain();

    // random runs across idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 35) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 67 : 35) : 0;
      for (int k = 0; k < 5; k++) push_run($urandom_range(10, 40));
      drain();
    end

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_req = 1'b1;
    push_run(20);
    push_run(20);
    push_run(10);
    drain();

    repeat (30000) @(posedge clk);
    if (errors == 0 && score_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
